// File: sv/sfd_pkg.sv
// Shared types and constants for the sync frame decoder with 8-bit Fletcher check.
// No dependencies; every other file imports this package.
package sfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1024;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BADCK = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_MSG     = 4'd3,
    PH_LENLO   = 4'd4,
    PH_LENHI   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  // one result word plus its valid flag, decoder to output stage
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] cls;
    logic [BYTE_W-1:0] msg;
    logic [LEN_W-1:0]  len;
    logic              frame_end;
  } res_t;

  // configuration seen by the decoder
  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

endpackage

// File: sv/sfd_if.sv
// Handshake channel interfaces: input byte, result word, configuration write.
// Depends on sfd_pkg.
interface sfd_byte_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface sfd_res_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] class_id;
  logic [BYTE_W-1:0] message_id;
  logic [LEN_W-1:0]  payload_length;
  logic              frame_end;
  modport source (output valid, output result_kind, output data_byte, output class_id,
                  output message_id, output payload_length, output frame_end, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input class_id,
                  input message_id, input payload_length, input frame_end, output ready);
endinterface

interface sfd_cfg_if import sfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// File: sv/sfd_decode.sv
// Frame parser state machine with running Fletcher sums; one byte per step.
// Depends on sfd_pkg.
module sfd_decode import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_val,
  input  cfg_t              cfg,
  output res_t              res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] cls_r, cls_nxt;
  logic [BYTE_W-1:0] msg_r, msg_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [BYTE_W-1:0] sa_r, sa_nxt;
  logic [BYTE_W-1:0] sb_r, sb_nxt;
  logic [BYTE_W-1:0] cka_r, cka_nxt;
  logic [BYTE_W-1:0] sa_add;
  logic [LEN_W-1:0]  len_full;

  assign sa_add   = sa_r + byte_val;
  assign len_full = {byte_val, len_r[BYTE_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      cls_r   <= '0;
      msg_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      cka_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cls_r   <= cls_nxt;
      msg_r   <= msg_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      cka_r   <= cka_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cls_nxt   = cls_r;
    msg_nxt   = msg_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    cka_nxt   = cka_r;
    res       = '0;
    res.kind  = KIND_DATA;
    unique case (phase_r)
      PH_HUNT2: begin
        // second sync wins over a repeated first sync
        if (byte_val == cfg.sync_second)     phase_nxt = PH_CLASS;
        else if (byte_val == cfg.sync_first) phase_nxt = PH_HUNT2;
        else                                 phase_nxt = PH_HUNT1;
      end
      PH_CLASS: begin
        cls_nxt   = byte_val;
        sa_nxt    = byte_val;
        sb_nxt    = byte_val;
        phase_nxt = PH_MSG;
      end
      PH_MSG: begin
        msg_nxt   = byte_val;
        sa_nxt    = sa_add;
        sb_nxt    = sb_r + sa_add;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt   = {{(LEN_W-BYTE_W){1'b0}}, byte_val};
        sa_nxt    = sa_add;
        sb_nxt    = sb_r + sa_add;
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt  = len_full;
        sa_nxt   = sa_add;
        sb_nxt   = sb_r + sa_add;
        left_nxt = len_full;
        if (len_full > cfg.max_payload) begin
          phase_nxt     = PH_HUNT1;
          res.valid     = 1'b1;
          res.kind      = KIND_LONG;
          res.frame_end = 1'b1;
        end else if (len_full == '0) begin
          phase_nxt = PH_CKA;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sa_nxt   = sa_add;
        sb_nxt   = sb_r + sa_add;
        left_nxt = left_r - 1'b1;
        if (left_r == LEN_W'(1)) phase_nxt = PH_CKA;
        res.valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = byte_val;
      end
      PH_CKA: begin
        cka_nxt   = byte_val;
        phase_nxt = PH_CKB;
      end
      PH_CKB: begin
        phase_nxt     = PH_HUNT1;
        res.valid     = 1'b1;
        res.frame_end = 1'b1;
        res.kind      = (cka_r == sa_r && byte_val == sb_r) ? KIND_GOOD : KIND_BADCK;
      end
      default: begin
        // hunting for first sync; unused codes fall here too
        phase_nxt = (byte_val == cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
    res.cls = cls_nxt;
    res.msg = msg_nxt;
    res.len = len_nxt;
  end

endmodule

// File: sv/sync_frame_decoder_fletcher8.sv
// Top level of the sync frame decoder: input register, parser, result register.
// Depends on sfd_pkg, the interfaces in sfd_if and sfd_decode.
//
// Byte stream frame decoder. Each input word is one received byte. The block
// hunts for the sync pair (sync_first, sync_second), then takes class, message
// id and a little-endian 16-bit payload length. Lengths above max_payload give
// one "length too large" word and hunting resumes. Otherwise every payload
// byte goes out as a kind 0 word, and after the two checksum bytes (A, B) a
// single frame-end word says good or checksum error. Every output word carries
// the current header. Rate: one byte per clock, sustained while each result word
// is read as soon as it is valid. A byte accepted into the input register is
// parsed when it leaves that register, and its result enters the result register
// at that same edge. The only thing that stalls input is a result word sitting
// unread while the byte in the input register is ready to move on. Configuration
// writes are always accepted and should only be issued with no bytes in flight.
module sync_frame_decoder_fletcher8 import sfd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  sfd_byte_if.sink   in_ch,
  sfd_res_if.source  out_ch,
  sfd_cfg_if.sink    cfg_ch
);

  // configuration registers
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_ch.data[BYTE_W-1:0];
        CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_ch.data[BYTE_W-1:0];
        CFG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_ch.data[LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_adv;     // result slot free: input register may move on
  logic              in_rdy;
  res_t              dec_res;
  res_t              out_r;
  res_t              out_nxt;

  assign s1_adv       = !out_r.valid || out_ch.ready;
  assign in_rdy       = !s1_valid_r || s1_adv;
  assign in_ch.ready  = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) s1_byte_r <= in_ch.byte_in;
  end

  // parser advances exactly once per byte, when it leaves the input register
  sfd_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_valid_r && s1_adv),
    .byte_val (s1_byte_r),
    .cfg      (cfg_r),
    .res      (dec_res)
  );

  // result register; valid only for a real byte that made a result
  always_comb begin
    out_nxt       = dec_res;
    out_nxt.valid = s1_valid_r && dec_res.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_r.valid;
  assign out_ch.result_kind    = out_r.kind;
  assign out_ch.data_byte      = out_r.data;
  assign out_ch.class_id       = out_r.cls;
  assign out_ch.message_id     = out_r.msg;
  assign out_ch.payload_length = out_r.len;
  assign out_ch.frame_end      = out_r.frame_end;

  // frame end marks exactly the non-payload kinds
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid |-> (out_r.frame_end == (out_r.kind != KIND_DATA)))
    else $error("frame_end disagrees with result kind");

  // data byte only on payload words
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && out_r.kind != KIND_DATA) |-> (out_r.data == '0))
    else $error("data byte set on a frame-end word");

  // input stalls only behind an unread result with a byte waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rdy |-> (s1_valid_r && out_r.valid && !out_ch.ready))
    else $error("input stalled without a pending result");

  // a stalled result word stays in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && !out_ch.ready) |=> (out_r.valid && $stable(out_r)))
    else $error("result word changed while stalled");

endmodule
